FILE: src/assert_macros.svh
// Assertion macros for the RTL; the overlap test top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/obbsat_pkg.sv
// Package: constants, register indexes and the quarter-wave sine generator.
`timescale 1ns / 1ps
`default_nettype none
package obbsat_pkg;
  localparam int HALF_BITS = 12;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_LENGTH = 1'b1;
  localparam logic [HALF_BITS-1:0] RST_HALF_WIDTH  = 12'd16;
  localparam logic [HALF_BITS-1:0] RST_HALF_LENGTH = 12'd32;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // First-quadrant sine of q steps, Taylor series in Q30, rounded to fbits.
  function automatic logic [31:0] quad_sin(input int q, input int abits, input int fbits);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    x = (PI_Q30 * 64'(q)) >> (abits - 1);
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      // Divide by (2n)(2n+1) for this term of the series
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        default: term = term / 64'd156;
      endcase
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) + (64'd1 << (29 - fbits))) >> (30 - fbits);
    if (r > (64'd1 << fbits)) r = 64'd1 << fbits;
    return r[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/obb_aabb_sat_overlap.sv
// Top level: pipelined separating-axis overlap test, oriented box against axis-aligned box.
// Pipeline stages in order: table, multiply, sum, compare; each one registers its results.
// Throughput: one item per cycle; the whole pipeline holds while out_stall blocks a result.
// in_stall rises only while a finished result waits and out_stall is high.
// Reset (rst_n low, synchronous): all stage valid bits clear, half width 16, half length 32.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module obb_aabb_sat_overlap import obbsat_pkg::*; #(
  parameter int ANGLE_BITS = 10,
  parameter int TRIG_FRAC_BITS = 14,
  parameter int COORD_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire signed [COORD_BITS-1:0]   in_obb_center_x,
  input  wire signed [COORD_BITS-1:0]   in_obb_center_z,
  input  wire        [ANGLE_BITS-1:0]   in_heading,
  input  wire signed [COORD_BITS-1:0]   in_box_center_x,
  input  wire signed [COORD_BITS-1:0]   in_box_center_z,
  input  wire        [HALF_BITS-1:0]    in_box_half_x,
  input  wire        [HALF_BITS-1:0]    in_box_half_z,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          out_overlap,
  input  wire                           cfg_we,
  input  wire        [CFG_IDX_BITS-1:0] cfg_index,
  input  wire        [HALF_BITS-1:0]    cfg_data
);
  localparam int FB = TRIG_FRAC_BITS;
  localparam int QN = 1 << (ANGLE_BITS - 2);   // steps in a quarter turn
  localparam int MW = FB + 1;                  // trig magnitude width
  localparam int SW = FB + 2;                  // signed trig width
  localparam int DW = COORD_BITS + 1;          // centre difference width
  localparam int PW = DW + SW;                 // signed product width
  localparam int UW = HALF_BITS + MW;          // unsigned product width
  localparam int CW = (PW + 1 > UW + 2) ? PW + 1 : UW + 2;  // compare width

  // Configuration registers
  logic [HALF_BITS-1:0] half_w_r, half_l_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_w_r <= RST_HALF_WIDTH;
      half_l_r <= RST_HALF_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_WIDTH:  half_w_r <= cfg_data;
        REG_HALF_LENGTH: half_l_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result waits on a stalled receiver
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Quarter-wave sine table, folded to constants at elaboration
  logic [MW-1:0] sin_tab [QN+1];
  for (genvar g = 0; g <= QN; g++) begin : g_tab
    localparam logic [31:0] TV = quad_sin(g, ANGLE_BITS, FB);
    assign sin_tab[g] = TV[MW-1:0];
  end

  // Stage 1: table lookup and centre differences
  logic [ANGLE_BITS-1:0] cos_ang;
  logic [ANGLE_BITS-2:0] s_idx, c_idx;
  assign cos_ang = in_heading + ANGLE_BITS'(QN);
  always_comb begin
    s_idx = in_heading[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QN) - {1'b0, in_heading[ANGLE_BITS-3:0]}
                                     : {1'b0, in_heading[ANGLE_BITS-3:0]};
    c_idx = cos_ang[ANGLE_BITS-2] ? (ANGLE_BITS-1)'(QN) - {1'b0, cos_ang[ANGLE_BITS-3:0]}
                                  : {1'b0, cos_ang[ANGLE_BITS-3:0]};
  end

  logic                 v1_r;
  logic [MW-1:0]        as1_r, ac1_r;
  logic signed [SW-1:0] s1_r, c1_r;
  logic signed [DW-1:0] dx1_r, dz1_r;
  logic [HALF_BITS-1:0] hx1_r, hz1_r;
  logic [MW-1:0]        as_nxt, ac_nxt;
  assign as_nxt = sin_tab[s_idx];
  assign ac_nxt = sin_tab[c_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      as1_r <= as_nxt;
      ac1_r <= ac_nxt;
      s1_r  <= in_heading[ANGLE_BITS-1] ? -$signed({1'b0, as_nxt}) : $signed({1'b0, as_nxt});
      c1_r  <= cos_ang[ANGLE_BITS-1] ? -$signed({1'b0, ac_nxt}) : $signed({1'b0, ac_nxt});
      dx1_r <= DW'(in_obb_center_x) - DW'(in_box_center_x);
      dz1_r <= DW'(in_obb_center_z) - DW'(in_box_center_z);
      hx1_r <= in_box_half_x;
      hz1_r <= in_box_half_z;
    end
  end

  // Stage 2: all products, one multiplier level, and the absolute centre differences
  logic                 v2_r;
  logic [UW-1:0]        hl_as_r, hw_ac_r, hl_ac_r, hw_as_r;
  logic [UW-1:0]        hx_as_r, hz_ac_r, hx_ac_r, hz_as_r;
  logic signed [PW-1:0] dxs_r, dzc_r, dzs_r, dxc_r;
  logic [DW-1:0]        mdx2_r, mdz2_r;
  logic [HALF_BITS-1:0] hx2_r, hz2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hl_as_r <= UW'(half_l_r) * UW'(as1_r);
      hw_ac_r <= UW'(half_w_r) * UW'(ac1_r);
      hl_ac_r <= UW'(half_l_r) * UW'(ac1_r);
      hw_as_r <= UW'(half_w_r) * UW'(as1_r);
      hx_as_r <= UW'(hx1_r) * UW'(as1_r);
      hz_ac_r <= UW'(hz1_r) * UW'(ac1_r);
      hx_ac_r <= UW'(hx1_r) * UW'(ac1_r);
      hz_as_r <= UW'(hz1_r) * UW'(as1_r);
      dxs_r   <= PW'(dx1_r) * PW'(s1_r);
      dzc_r   <= PW'(dz1_r) * PW'(c1_r);
      dzs_r   <= PW'(dz1_r) * PW'(s1_r);
      dxc_r   <= PW'(dx1_r) * PW'(c1_r);
      mdx2_r  <= dx1_r[DW-1] ? DW'(-dx1_r) : DW'(dx1_r);
      mdz2_r  <= dz1_r[DW-1] ? DW'(-dz1_r) : DW'(dz1_r);
      // Carry the box half extents alongside the products
      hx2_r   <= hx1_r;
      hz2_r   <= hz1_r;
    end
  end

  // Stage 3: projected radii and centre distances per axis
  logic                 v3_r;
  logic [CW-1:0]        lx3_r, rx3_r, lz3_r, rz3_r, lf3_r, rf3_r, lr3_r, rr3_r;
  logic signed [CW-1:0] fwd_nxt, rgt_nxt;
  assign fwd_nxt = CW'(dxs_r) + CW'(dzc_r);
  assign rgt_nxt = CW'(dzs_r) - CW'(dxc_r);
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      lx3_r <= CW'(mdx2_r) << FB;
      rx3_r <= CW'(hl_as_r) + CW'(hw_ac_r) + (CW'(hx2_r) << FB);
      lz3_r <= CW'(mdz2_r) << FB;
      rz3_r <= CW'(hl_ac_r) + CW'(hw_as_r) + (CW'(hz2_r) << FB);
      lf3_r <= fwd_nxt[CW-1] ? CW'(-fwd_nxt) : CW'(fwd_nxt);
      rf3_r <= (CW'(half_l_r) << FB) + CW'(hx_as_r) + CW'(hz_ac_r);
      lr3_r <= rgt_nxt[CW-1] ? CW'(-rgt_nxt) : CW'(rgt_nxt);
      rr3_r <= (CW'(half_w_r) << FB) + CW'(hx_ac_r) + CW'(hz_as_r);
    end
  end

  // Stage 4: compare every axis and register the result
  logic out_overlap_nxt;
  assign out_overlap_nxt = (lx3_r <= rx3_r) && (lz3_r <= rz3_r) &&
                           (lf3_r <= rf3_r) && (lr3_r <= rr3_r);
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) out_overlap <= out_overlap_nxt;
  end

  // An accepted item reaches the output once it has advanced through the multiply, sum and compare stages
  `ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && !in_stall) ##1 adv ##1 adv ##1 adv, out_valid)
  // A held pipeline keeps its result
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !adv, out_valid && $stable(out_overlap))
  // Input side stalls only behind a waiting result
  `ASSERT_IMPL(a_stall, clk, rst_n, in_stall, out_valid)
endmodule
`default_nettype wire
